// ===== sv/cwtg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwtg_pkg
// shared widths, codes and controller/datapath interface types for the
// caption window text grid
// ----------------------------------------------------------------------------
package cwtg_pkg;

    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLUMNS_DEF = 64;

    localparam int OP_W   = 3;
    localparam int CHAR_W = 16;
    localparam int ATTR_W = 38;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;
    localparam int NROW_W = 5;
    localparam int NCOL_W = 7;
    localparam int STY_W  = 3;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_SETPEN = 3'd2;
    localparam logic [OP_W-1:0] OP_DEFINE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_BS    = 16'h0008;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

    localparam logic [STY_W-1:0] STYLE_DEFAULT = 3'd1;
    localparam logic [STY_W-1:0] STYLE_VERT    = 3'd7;

    localparam logic [1:0] DIR_LTR = 2'd0;
    localparam logic [1:0] DIR_RTL = 2'd1;
    localparam logic [1:0] DIR_TTB = 2'd2;
    localparam logic [1:0] DIR_BTT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WRITE, S_SCROLL, S_COPY_RD, S_COPY_WR,
        S_FILL, S_PEN, S_READ_REQ, S_READ_WAIT, S_RESULT
    } t_state;

    typedef enum logic [1:0] {CI_ZERO, CI_LAST, CI_DEF} t_cnt_init;
    typedef enum logic [1:0] {DF_NONE, DF_EXTEND, DF_FULL} t_def_fill;

    typedef struct packed {
        logic      capture;
        logic      def_apply;
        logic      pen_apply;
        logic      cell_wr;
        logic      fill_step;
        logic      copy_rd;
        logic      copy_wr;
        logic      rd_req;
        logic      cell_out;
        logic      res_out;
        logic      cnt_init;
        t_cnt_init init_sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            win;
        logic            is_cr;
        logic            is_bs;
        logic            need_scroll;
        logic            rr_oob;
        logic            rows_ge2;
        logic            fill_done;
        logic            copy_done;
        logic            row_end;
        logic            out_free;
        t_def_fill       def_fill;
    } t_stat;

endpackage
`default_nettype wire

// ===== sv/caption_window_text_grid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// caption_window_text_grid
// caption window character grid with pen cursor, one item at a time
// ----------------------------------------------------------------------------
// a fill writes the cells one by one, a scroll copies each cell up a row
//   and then blanks the last row, and a read row returns its cells one by
//   one; one item at a time, the next transfer taken once its result is
//   registered; output stalls hold the block until the output register is free
// reset: synchronous active low, no window, pen home; cell memory not cleared
module caption_window_text_grid #(
    parameter int MAX_ROWS    = cwtg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = cwtg_pkg::MAX_COLUMNS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // input item channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [cwtg_pkg::OP_W-1:0]    i_opcode,
    input  wire [cwtg_pkg::CHAR_W-1:0]  i_char_code,
    input  wire [cwtg_pkg::ATTR_W-1:0]  i_attr,
    input  wire [cwtg_pkg::ROW_W-1:0]   i_row,
    input  wire [cwtg_pkg::COL_W-1:0]   i_column,
    input  wire [cwtg_pkg::ROW_W-1:0]   i_rows_minus_one,
    input  wire [cwtg_pkg::COL_W-1:0]   i_cols_minus_one,
    input  wire                         i_lock_rows,
    input  wire                         i_lock_columns,
    input  wire [cwtg_pkg::STY_W-1:0]   i_window_style,
    // result channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_status,
    output logic [cwtg_pkg::CHAR_W-1:0] o_cell_char,
    output logic [cwtg_pkg::ATTR_W-1:0] o_cell_attr,
    output logic                        o_new_run,
    output logic [cwtg_pkg::COL_W-1:0]  o_cell_column,
    output logic [cwtg_pkg::ROW_W-1:0]  o_pen_row_now,
    output logic [cwtg_pkg::COL_W-1:0]  o_pen_column_now,
    output logic                        o_last
);
    import cwtg_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: takes a transfer only when idle
    cwtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: grid memory, pen, output register that holds a result
    // while the next item is taken
    cwtg_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_attr           (i_attr),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_rows_minus_one (i_rows_minus_one),
        .i_cols_minus_one (i_cols_minus_one),
        .i_lock_rows      (i_lock_rows),
        .i_lock_columns   (i_lock_columns),
        .i_window_style   (i_window_style),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_cell_char      (o_cell_char),
        .o_cell_attr      (o_cell_attr),
        .o_new_run        (o_new_run),
        .o_cell_column    (o_cell_column),
        .o_pen_row_now    (o_pen_row_now),
        .o_pen_column_now (o_pen_column_now),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire

// ===== sv/cwtg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwtg_ctrl
// sequencer: steps each item through writes, scroll copy, fills and reads
// ----------------------------------------------------------------------------
module cwtg_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire cwtg_pkg::t_stat i_stat,
    output cwtg_pkg::t_cmd       o_cmd
);
    import cwtg_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.init_sel = CI_ZERO;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_DEFINE) begin
                    o_cmd.def_apply = 1'b1;
                    o_cmd.cnt_init  = 1'b1;
                    o_cmd.init_sel  = CI_DEF;
                    n_state = (i_stat.def_fill != DF_NONE) ? S_FILL : S_RESULT;
                end else if (i_stat.op > OP_READ || !i_stat.win) begin
                    n_state = S_RESULT;
                end else if (i_stat.op == OP_ADD) begin
                    if (i_stat.is_cr || i_stat.is_bs) begin
                        n_state = i_stat.need_scroll ? S_SCROLL : S_PEN;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if (i_stat.op == OP_CLEAR) begin
                    o_cmd.cnt_init = 1'b1;
                    n_state = S_FILL;
                end else if (i_stat.op == OP_SETPEN) begin
                    n_state = i_stat.need_scroll ? S_SCROLL : S_PEN;
                end else if (i_stat.rr_oob) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.cnt_init = 1'b1;
                    n_state = S_READ_REQ;
                end
            end
            S_WRITE: begin
                o_cmd.cell_wr = 1'b1;
                if (i_stat.is_bs) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = i_stat.need_scroll ? S_SCROLL : S_PEN;
                end
            end
            S_SCROLL: begin
                o_cmd.cnt_init = 1'b1;
                o_cmd.init_sel = i_stat.rows_ge2 ? CI_ZERO : CI_LAST;
                n_state = i_stat.rows_ge2 ? S_COPY_RD : S_FILL;
            end
            S_COPY_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = i_stat.copy_done ? S_FILL : S_COPY_RD;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_done) begin
                    if (i_stat.op == OP_ADD || i_stat.op == OP_SETPEN) begin
                        n_state = S_PEN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_PEN: begin
                o_cmd.pen_apply = 1'b1;
                n_state = (i_stat.op == OP_ADD && i_stat.is_bs) ? S_WRITE : S_RESULT;
            end
            S_READ_REQ: begin
                o_cmd.rd_req = 1'b1;
                n_state = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.cell_out = 1'b1;
                    n_state = i_stat.row_end ? S_IDLE : S_READ_REQ;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.res_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/cwtg_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cwtg_dpath
// window registers, pen arithmetic, cell memory, sweep counters, output stage
// ----------------------------------------------------------------------------
module cwtg_dpath #(
    parameter int MAX_ROWS    = cwtg_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = cwtg_pkg::MAX_COLUMNS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire cwtg_pkg::t_cmd            i_cmd,
    output cwtg_pkg::t_stat                o_stat,
    input  wire [cwtg_pkg::OP_W-1:0]       i_opcode,
    input  wire [cwtg_pkg::CHAR_W-1:0]     i_char_code,
    input  wire [cwtg_pkg::ATTR_W-1:0]     i_attr,
    input  wire [cwtg_pkg::ROW_W-1:0]      i_row,
    input  wire [cwtg_pkg::COL_W-1:0]      i_column,
    input  wire [cwtg_pkg::ROW_W-1:0]      i_rows_minus_one,
    input  wire [cwtg_pkg::COL_W-1:0]      i_cols_minus_one,
    input  wire                            i_lock_rows,
    input  wire                            i_lock_columns,
    input  wire [cwtg_pkg::STY_W-1:0]      i_window_style,
    input  wire                            i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_status,
    output logic [cwtg_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [cwtg_pkg::ATTR_W-1:0]    o_cell_attr,
    output logic                           o_new_run,
    output logic [cwtg_pkg::COL_W-1:0]     o_cell_column,
    output logic [cwtg_pkg::ROW_W-1:0]     o_pen_row_now,
    output logic [cwtg_pkg::COL_W-1:0]     o_pen_column_now,
    output logic                           o_last
);
    import cwtg_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    // captured item
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]  r_rr, r_rm1;
    logic [COL_W-1:0]  r_cc, r_cm1;
    logic              r_lr, r_lc;
    logic [STY_W-1:0]  r_sty;

    // window state
    logic              r_win, r_lockr, r_lockc, r_scroll;
    logic [NROW_W-1:0] r_rows;
    logic [NCOL_W-1:0] r_cols;
    logic [ROW_W-1:0]  r_prow;
    logic [COL_W-1:0]  r_pcol;
    logic [1:0]        r_dir;

    // sweep counters and memory
    logic [ROW_W-1:0]  r_r;
    logic [COL_W-1:0]  r_c;
    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] r_rd;
    logic [ATTR_W-1:0] r_prev;

    logic is_cr, is_bs;
    assign is_cr = (r_ch == CH_CR);
    assign is_bs = (r_ch == CH_BS);

    // pen move
    logic signed [7:0] dc, dr, nc, nr, fr, fc, rows_s, cols_s;
    logic              ms, wrap, need_scroll;

    always_comb begin
        rows_s = $signed({3'b000, r_rows});
        cols_s = $signed({1'b0, r_cols});
        dc = 8'sd0;
        dr = 8'sd0;
        case (r_dir)
            DIR_LTR: dc = 8'sd1;
            DIR_RTL: dc = -8'sd1;
            DIR_TTB: dr = 8'sd1;
            default: dr = -8'sd1;
        endcase
        if (is_bs) begin
            dc = -dc;
            dr = -dr;
        end
        nc = $signed({2'b00, r_pcol}) + dc;
        nr = $signed({4'b0000, r_prow}) + dr;
        wrap = !r_lockr && r_lockc;
        ms = 1'b0;
        if (r_dir == DIR_LTR || r_dir == DIR_RTL) begin
            ms = 1'b1;
            if (wrap && nc >= cols_s) begin
                nc = 8'sd0;
                nr = nr + 8'sd1;
            end else if (wrap && nc < 8'sd0) begin
                nc = cols_s - 8'sd1;
                nr = nr - 8'sd1;
            end
        end
        if (r_op == OP_SETPEN) begin
            nr = $signed({4'b0000, r_rr});
            nc = $signed({2'b00, r_cc});
            ms = 1'b1;
        end else if (is_cr) begin
            nr = $signed({4'b0000, r_prow}) + 8'sd1;
            nc = 8'sd0;
            ms = 1'b1;
        end
        need_scroll = ms && r_scroll && (nr >= rows_s);
        fr = need_scroll ? rows_s - 8'sd1 : nr;
        fc = nc;
        if (fr < 8'sd0) fr = 8'sd0;
        if (fc < 8'sd0) fc = 8'sd0;
        if (fr > rows_s - 8'sd1) fr = rows_s - 8'sd1;
        if (fc > cols_s - 8'sd1) fc = cols_s - 8'sd1;
    end

    // define sizing
    logic [NROW_W-1:0] nrows;
    logic [NCOL_W-1:0] ncols;
    logic              extend, full;
    logic [STY_W-1:0]  sty_eff;

    always_comb begin
        nrows = {1'b0, r_rm1} + NROW_W'(1);
        ncols = {1'b0, r_cm1} + NCOL_W'(1);
        if (nrows > NROW_W'(MAX_ROWS)) nrows = NROW_W'(MAX_ROWS);
        if (ncols > NCOL_W'(MAX_COLUMNS)) ncols = NCOL_W'(MAX_COLUMNS);
        extend  = r_win && (r_cols == ncols) && (r_rows < nrows);
        full    = !extend && (!r_win || r_rows != nrows || r_cols != ncols);
        sty_eff = (r_sty == '0) ? STYLE_DEFAULT : r_sty;
    end

    logic row_end, row_last, row_pen;
    assign row_end  = ({1'b0, r_c} == r_cols - NCOL_W'(1));
    assign row_last = ({1'b0, r_r} == r_rows - NROW_W'(1));
    assign row_pen  = ({1'b0, r_r} == r_rows - NROW_W'(2));

    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_stat.op          = r_op;
        o_stat.win         = r_win;
        o_stat.is_cr       = is_cr;
        o_stat.is_bs       = is_bs;
        o_stat.need_scroll = need_scroll;
        o_stat.rr_oob      = ({1'b0, r_rr} >= r_rows);
        o_stat.rows_ge2    = (r_rows >= NROW_W'(2));
        o_stat.fill_done   = row_end && row_last;
        o_stat.copy_done   = row_end && row_pen;
        o_stat.row_end     = row_end;
        o_stat.out_free    = out_free;
        o_stat.def_fill    = extend ? DF_EXTEND : (full ? DF_FULL : DF_NONE);
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_ch   <= i_char_code;
            r_attr <= i_attr;
            r_rr   <= i_row;
            r_cc   <= i_column;
            r_rm1  <= i_rows_minus_one;
            r_cm1  <= i_cols_minus_one;
            r_lr   <= i_lock_rows;
            r_lc   <= i_lock_columns;
            r_sty  <= i_window_style;
        end
    end

    // window and pen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= 1'b0;
            r_rows   <= '0;
            r_cols   <= '0;
            r_prow   <= '0;
            r_pcol   <= '0;
            r_lockr  <= 1'b0;
            r_lockc  <= 1'b0;
            r_dir    <= DIR_LTR;
            r_scroll <= 1'b0;
        end else if (i_cmd.def_apply) begin
            r_lockr <= r_lr;
            r_lockc <= r_lc;
            if (r_sty != '0 || !r_win) begin
                r_scroll <= (sty_eff < STYLE_VERT);
                r_dir    <= (sty_eff < STYLE_VERT) ? DIR_LTR : DIR_TTB;
            end
            r_rows <= nrows;
            r_cols <= ncols;
            if (extend || full) begin
                r_prow <= '0;
                r_pcol <= '0;
            end
            r_win <= 1'b1;
        end else if (i_cmd.pen_apply) begin
            r_prow <= fr[ROW_W-1:0];
            r_pcol <= fc[COL_W-1:0];
        end
    end

    // sweep counters
    logic [NROW_W-1:0] last_row;
    assign last_row = r_rows - NROW_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_init) begin
            r_c <= '0;
            case (i_cmd.init_sel)
                CI_LAST: r_r <= last_row[ROW_W-1:0];
                CI_DEF:  r_r <= extend ? r_rows[ROW_W-1:0] : '0;
                default: r_r <= '0;
            endcase
        end else if (i_cmd.fill_step || i_cmd.copy_wr) begin
            if (row_end) begin
                r_c <= '0;
                r_r <= r_r + ROW_W'(1);
            end else begin
                r_c <= r_c + COL_W'(1);
            end
        end else if (i_cmd.cell_out) begin
            r_c <= r_c + COL_W'(1);
        end
    end

    // cell memory
    logic [ROW_W-1:0]  next_row;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [CELL_W-1:0] wdata;

    assign next_row = r_r + ROW_W'(1);

    always_comb begin
        we    = i_cmd.cell_wr || i_cmd.fill_step || i_cmd.copy_wr;
        re    = i_cmd.copy_rd || i_cmd.rd_req;
        waddr = {r_r[RW-1:0], r_c[CW-1:0]};
        wdata = {CH_SPACE, r_attr};
        if (i_cmd.cell_wr) begin
            waddr = {r_prow[RW-1:0], r_pcol[CW-1:0]};
            wdata = {(is_bs ? CH_SPACE : r_ch), r_attr};
        end else if (i_cmd.copy_wr) begin
            wdata = r_rd;
        end
        raddr = i_cmd.copy_rd ? {next_row[RW-1:0], r_c[CW-1:0]}
                              : {r_rr[RW-1:0], r_c[CW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.res_out || i_cmd.cell_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_out) begin
            o_status         <= (r_op != OP_DEFINE) && (r_op <= OP_READ) && !r_win;
            o_cell_char      <= '0;
            o_cell_attr      <= '0;
            o_new_run        <= 1'b0;
            o_cell_column    <= '0;
            o_pen_row_now    <= r_prow;
            o_pen_column_now <= r_pcol;
            o_last           <= 1'b1;
        end else if (i_cmd.cell_out) begin
            o_status         <= 1'b0;
            o_cell_char      <= r_rd[CELL_W-1:ATTR_W];
            o_cell_attr      <= r_rd[ATTR_W-1:0];
            o_new_run        <= (r_c == '0) || (r_rd[ATTR_W-1:0] != r_prev);
            o_cell_column    <= r_c;
            o_pen_row_now    <= r_prow;
            o_pen_column_now <= r_pcol;
            o_last           <= row_end;
            r_prev           <= r_rd[ATTR_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== sim/caption_window_text_grid_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// caption_window_text_grid_tb
// self-checking bench: directed table then random caption traffic, every
// result compared against a behavioral grid and pen model kept in the bench
// ----------------------------------------------------------------------------
module caption_window_text_grid_tb;
    import cwtg_pkg::*;

    localparam int CELLS     = MAX_ROWS_DEF * MAX_COLUMNS_DEF;
    localparam int RAND_ITEMS = 382;
    localparam int CYCLE_LIMIT = 10000000;

    // one input transfer
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  rm1;
        logic [COL_W-1:0]  cm1;
        logic              lk_r;
        logic              lk_c;
        logic [STY_W-1:0]  sty;
    } t_item;

    // one result transfer
    typedef struct {
        logic              status;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic              run;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  prow;
        logic [COL_W-1:0]  pcol;
        logic              last;
    } t_res;

    // directed row: the expectation is typed in only when typed is set
    typedef struct {
        t_item it;
        bit    typed;
        logic  st;
        int    pr;
        int    pc;
    } t_dir;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [OP_W-1:0] i_opcode = '0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ATTR_W-1:0] i_attr = '0;
    logic [ROW_W-1:0] i_row = '0;
    logic [COL_W-1:0] i_column = '0;
    logic [ROW_W-1:0] i_rows_minus_one = '0;
    logic [COL_W-1:0] i_cols_minus_one = '0;
    logic i_lock_rows = 1'b0;
    logic i_lock_columns = 1'b0;
    logic [STY_W-1:0] i_window_style = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_status;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;
    logic o_new_run;
    logic [COL_W-1:0] o_cell_column;
    logic [ROW_W-1:0] o_pen_row_now;
    logic [COL_W-1:0] o_pen_column_now;
    logic o_last;

    caption_window_text_grid dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_char_code(i_char_code), .i_attr(i_attr),
        .i_row(i_row), .i_column(i_column),
        .i_rows_minus_one(i_rows_minus_one), .i_cols_minus_one(i_cols_minus_one),
        .i_lock_rows(i_lock_rows), .i_lock_columns(i_lock_columns),
        .i_window_style(i_window_style),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_cell_char(o_cell_char), .o_cell_attr(o_cell_attr),
        .o_new_run(o_new_run), .o_cell_column(o_cell_column),
        .o_pen_row_now(o_pen_row_now), .o_pen_column_now(o_pen_column_now),
        .o_last(o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // bench copy of the window: grid, pen, locks, style
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] grid_ch [CELLS];
    logic [ATTR_W-1:0] grid_at [CELLS];
    bit        win_ok;
    int        win_rows, win_cols;
    int        pen_r, pen_c;
    bit        lock_r, lock_c;
    logic [1:0] pen_dir;
    bit        roll_up;

    t_res pending_cells[$];
    int   err_count = 0;
    int   cyc = 0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic put_cell(input int idx, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] at);
        if (idx < CELLS) begin
            grid_ch[idx] = ch;
            grid_at[idx] = at;
        end
    endtask

    task automatic blank_cells(input int lo, input int hi, input logic [ATTR_W-1:0] at);
        for (int i = lo; i < hi; i++) put_cell(i, CH_SPACE, at);
    endtask

    // pen move with optional roll-up, then clamp into the window
    task automatic move_pen(input int nr, input int nc, input bit may_roll,
                            input logic [ATTR_W-1:0] at);
        int d;
        if (may_roll && roll_up && nr >= win_rows) begin
            for (int r = 0; r + 1 < win_rows; r++)
                for (int c = 0; c < win_cols; c++) begin
                    d = r * win_cols + c;
                    if (d + win_cols < CELLS) begin
                        grid_ch[d] = grid_ch[d + win_cols];
                        grid_at[d] = grid_at[d + win_cols];
                    end
                end
            blank_cells((win_rows - 1) * win_cols, win_rows * win_cols, at);
            nr = win_rows - 1;
        end
        if (nr < 0) nr = 0;
        if (nc < 0) nc = 0;
        if (nr > win_rows - 1) nr = win_rows - 1;
        if (nc > win_cols - 1) nc = win_cols - 1;
        pen_r = nr;
        pen_c = nc;
    endtask

    // one step along the print direction, wrapping only with column lock alone
    task automatic advance_pen(input int sgn, input logic [ATTR_W-1:0] at);
        int dc, dr, nc, nr;
        bit wrap;
        dc = (pen_dir == DIR_LTR) ? 1 : (pen_dir == DIR_RTL) ? -1 : 0;
        dr = (pen_dir == DIR_TTB) ? 1 : (pen_dir == DIR_BTT) ? -1 : 0;
        nc = pen_c + sgn * dc;
        nr = pen_r + sgn * dr;
        wrap = !lock_r && lock_c;
        if (pen_dir == DIR_LTR || pen_dir == DIR_RTL) begin
            if (wrap && nc >= win_cols) begin
                nc = 0;
                nr++;
            end else if (wrap && nc < 0) begin
                nc = win_cols - 1;
                nr--;
            end
            move_pen(nr, nc, 1'b1, at);
        end else begin
            move_pen(nr, nc, 1'b0, at);
        end
    endtask

    task automatic push_res(input logic st, input logic [CHAR_W-1:0] ch,
                            input logic [ATTR_W-1:0] at, input logic run,
                            input int col, input logic last);
        t_res r;
        r.status = st; r.ch = ch; r.attr = at; r.run = run;
        r.col = col[COL_W-1:0];
        r.prow = pen_r[ROW_W-1:0];
        r.pcol = pen_c[COL_W-1:0];
        r.last = last;
        pending_cells.insert(pending_cells.size(), r);
    endtask

    // applies one accepted item to the bench window and queues its results
    task automatic grid_predict(input t_item t);
        int nr, nc, orow, ocol, sty, idx;
        logic [ATTR_W-1:0] prev;
        if (t.op == OP_DEFINE) begin
            nr = int'(t.rm1) + 1;
            nc = int'(t.cm1) + 1;
            sty = int'(t.sty);
            orow = win_rows;
            ocol = win_cols;
            lock_r = t.lk_r;
            lock_c = t.lk_c;
            if (sty != 0 || !win_ok) begin
                if (sty == 0) sty = int'(STYLE_DEFAULT);
                roll_up = sty < int'(STYLE_VERT);
                pen_dir = roll_up ? DIR_LTR : DIR_TTB;
            end
            win_rows = nr;
            win_cols = nc;
            if (win_ok && ocol == nc && orow < nr) begin
                blank_cells(orow * ocol, nr * nc, t.attr);
                pen_r = 0;
                pen_c = 0;
            end else if (!win_ok || orow != nr || ocol != nc) begin
                blank_cells(0, nr * nc, t.attr);
                pen_r = 0;
                pen_c = 0;
            end
            win_ok = 1'b1;
            push_res(1'b0, '0, '0, 1'b0, 0, 1'b1);
        end else if (t.op > OP_READ) begin
            push_res(1'b0, '0, '0, 1'b0, 0, 1'b1);
        end else if (!win_ok) begin
            push_res(1'b1, '0, '0, 1'b0, 0, 1'b1);
        end else if (t.op == OP_READ) begin
            if (int'(t.row) >= win_rows) begin
                push_res(1'b0, '0, '0, 1'b0, 0, 1'b1);
            end else begin
                prev = '0;
                for (int c = 0; c < win_cols; c++) begin
                    idx = int'(t.row) * win_cols + c;
                    push_res(1'b0, grid_ch[idx], grid_at[idx],
                             (c == 0) || (grid_at[idx] != prev), c, c + 1 == win_cols);
                    prev = grid_at[idx];
                end
            end
        end else begin
            case (t.op)
                OP_ADD: begin
                    if (t.ch == CH_CR) begin
                        move_pen(pen_r + 1, 0, 1'b1, t.attr);
                    end else if (t.ch == CH_BS) begin
                        advance_pen(-1, t.attr);
                        put_cell(pen_r * win_cols + pen_c, CH_SPACE, t.attr);
                    end else begin
                        put_cell(pen_r * win_cols + pen_c, t.ch, t.attr);
                        advance_pen(1, t.attr);
                    end
                end
                OP_CLEAR: blank_cells(0, win_rows * win_cols, t.attr);
                default: move_pen(int'(t.row), int'(t.col), 1'b1, t.attr);
            endcase
            push_res(1'b0, '0, '0, 1'b0, 0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // sender: holds the item until the transfer, then predicts it
    // ------------------------------------------------------------------
    task automatic send_item(input t_item t);
        i_in_valid <= 1'b1;
        i_opcode <= t.op;
        i_char_code <= t.ch;
        i_attr <= t.attr;
        i_row <= t.row;
        i_column <= t.col;
        i_rows_minus_one <= t.rm1;
        i_cols_minus_one <= t.cm1;
        i_lock_rows <= t.lk_r;
        i_lock_columns <= t.lk_c;
        i_window_style <= t.sty;
        do @(posedge i_clk); while (o_in_stall);
        grid_predict(t);
    endtask

    int burst_left = 0;
    bit gaps_on = 1'b1;

    // bursts of back-to-back transfers separated by random gaps while gaps_on is set
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    function automatic t_item mk(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                 input logic [ATTR_W-1:0] at, input int r, input int c,
                                 input int rm, input int cm, input bit lr, input bit lc,
                                 input int sty);
        t_item t;
        t.op = op; t.ch = ch; t.attr = at;
        t.row = r[ROW_W-1:0]; t.col = c[COL_W-1:0];
        t.rm1 = rm[ROW_W-1:0]; t.cm1 = cm[COL_W-1:0];
        t.lk_r = lr; t.lk_c = lc; t.sty = sty[STY_W-1:0];
        return t;
    endfunction

    // ------------------------------------------------------------------
    // receiver: stall pattern picked at random from four, one of them calm
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_span = 0;
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(50, 300);
            stall_mode <= $urandom_range(0, 3);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result checker, pre-edge values seen right after the clock
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cells.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = pending_cells.pop_front();
                if (o_status !== e.status)
                    report($sformatf("status %0b exp %0b", o_status, e.status));
                if (o_cell_char !== e.ch)
                    report($sformatf("cell_char %h exp %h", o_cell_char, e.ch));
                if (o_cell_attr !== e.attr)
                    report($sformatf("cell_attr %h exp %h", o_cell_attr, e.attr));
                if (o_new_run !== e.run)
                    report($sformatf("new_run %0b exp %0b", o_new_run, e.run));
                if (o_cell_column !== e.col)
                    report($sformatf("cell_column %0d exp %0d", o_cell_column, e.col));
                if (o_pen_row_now !== e.prow)
                    report($sformatf("pen_row %0d exp %0d", o_pen_row_now, e.prow));
                if (o_pen_column_now !== e.pcol)
                    report($sformatf("pen_column %0d exp %0d", o_pen_column_now, e.pcol));
                if (o_last !== e.last)
                    report($sformatf("last %0b exp %0b", o_last, e.last));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_dir tbl[$];
        t_item t;
        t_res r;
        logic [ATTR_W-1:0] pool [3];
        logic [ATTR_W-1:0] ones;
        int k, sent;
        ones = '1;

        win_ok = 1'b0; win_rows = 0; win_cols = 0; pen_r = 0; pen_c = 0;
        lock_r = 1'b0; lock_c = 1'b0; pen_dir = DIR_LTR; roll_up = 1'b0;

        // no window yet: add, read, clear and set pen are refused
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h0041, ones, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b1, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b1, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_CLEAR, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b1, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_SETPEN, '0, '0, 3, 3, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b1, 0, 0});
        // unused opcodes do nothing
        tbl.insert(tbl.size(), '{mk(3'd5, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(3'd7, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b1, 1'b0, 0, 0});
        // first define, style 0 falls back to the default style, pen home
        tbl.insert(tbl.size(), '{mk(OP_DEFINE, '0, '0, 0, 0, 2, 3, 1'b0, 1'b1, 0),
                                 1'b1, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'hFFFF, ones, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h0000, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, CH_CR, 38'h15, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, CH_BS, 38'h2A, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        // pen target past the window clamps, then a write wraps and rolls up
        tbl.insert(tbl.size(), '{mk(OP_SETPEN, '0, '0, 15, 63, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h0078, 38'h7, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 2, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 15, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        // more rows, same columns: old cells kept
        tbl.insert(tbl.size(), '{mk(OP_DEFINE, '0, 38'h33, 0, 0, 5, 3, 1'b1, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_CLEAR, '0, ones, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        // largest window, vertical style
        tbl.insert(tbl.size(), '{mk(OP_DEFINE, '0, 38'h1, 0, 0, 15, 63, 1'b1, 1'b1, 7),
                                 1'b1, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h0061, 38'h2, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, CH_BS, 38'h3, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_SETPEN, '0, '0, 15, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h8000, 38'h2000000000, 0, 0, 0, 0,
                                    1'b0, 1'b0, 0), 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 15, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        // same size keeps cells and pen; then the smallest window
        tbl.insert(tbl.size(), '{mk(OP_DEFINE, '0, '0, 0, 0, 15, 63, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_DEFINE, '0, 38'h9, 0, 0, 0, 0, 1'b0, 1'b0, 6),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_ADD, 16'h0042, 38'h9, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});
        tbl.insert(tbl.size(), '{mk(OP_READ, '0, '0, 0, 0, 0, 0, 1'b0, 1'b0, 0),
                                 1'b0, 1'b0, 0, 0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tbl[n]) begin
            send_item(tbl[n].it);
            if (tbl[n].typed) begin
                // replace the model result with the hand-written one
                r = pending_cells.pop_back();
                r.status = tbl[n].st;
                r.prow = ROW_W'(tbl[n].pr);
                r.pcol = COL_W'(tbl[n].pc);
                pending_cells.insert(pending_cells.size(), r);
            end
            pace_sender();
        end

        // hold the sender until the block has drained
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);

        foreach (pool[p]) pool[p] = ATTR_W'({$urandom(), $urandom()});
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
            k = $urandom_range(0, 99);
            t = mk(OP_ADD, CHAR_W'($urandom()), pool[$urandom_range(0, 2)],
                   $urandom(), $urandom(), $urandom(), $urandom(),
                   1'($urandom()), 1'($urandom()), $urandom());
            if ($urandom_range(0, 9) == 0) t.attr = ATTR_W'({$urandom(), $urandom()});
            if (k < 6) begin
                // new window, small sizes mostly
                t.op = OP_DEFINE;
                if ($urandom_range(0, 9) != 0) begin
                    t.rm1 = ROW_W'($urandom_range(0, 3));
                    t.cm1 = COL_W'($urandom_range(0, 7));
                end
                foreach (pool[p]) pool[p] = ATTR_W'({$urandom(), $urandom()});
            end else if (k < 56) begin
                case ($urandom_range(0, 9))
                    0, 1: t.ch = CH_CR;
                    2, 3: t.ch = CH_BS;
                    4: t.ch = CHAR_W'($urandom_range('h20, 'h7E));
                    default: ;
                endcase
            end else if (k < 68) begin
                t.op = OP_SETPEN;
                if ($urandom_range(0, 1) != 0) begin
                    t.row = ROW_W'($urandom_range(0, 4));
                    t.col = COL_W'($urandom_range(0, 8));
                end
            end else if (k < 90) begin
                t.op = OP_READ;
                if ($urandom_range(0, 3) != 0) t.row = ROW_W'($urandom_range(0, 4));
            end else if (k < 96) begin
                t.op = OP_CLEAR;
            end else begin
                t.op = OP_W'($urandom_range(5, 7));
            end
            send_item(t);
            sent++;
            pace_sender();
        end
        i_in_valid <= 1'b0;

        while (pending_cells.size() != 0) @(posedge i_clk);
        // catch stray results after the last expected one
        repeat (300) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cwtg_pkg.sv
sv/cwtg_ctrl.sv
sv/cwtg_dpath.sv
sv/caption_window_text_grid.sv
sim/caption_window_text_grid_tb.sv
